[rtl/tdpt_pkg.sv]
// shared types, constants and the control program of the trial division prime test
// no dependencies; used by the datapath, the sequencer and the top level
`default_nettype none

package tdpt_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int PC_W            = 4;

    typedef logic [PC_W-1:0] t_pc;

    // program addresses that are jumped to
    localparam t_pc PC_START = t_pc'(0);
    localparam t_pc PC_LOOP  = t_pc'(7);

    // divisor register operations
    typedef enum logic [2:0] {
        D_HOLD,
        D_SET2,
        D_SET3,
        D_SET5,
        D_ADD2,
        D_ADD4
    } t_d_op;

    // branch conditions
    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_LT2,
        C_LT4,
        C_REM0,
        C_DGTQ
    } t_cond;

    // one control word
    typedef struct packed {
        t_d_op d_op;
        logic  div;
        t_cond cond;
        logic  fin;
        logic  res;
        t_pc   target;
    } t_uword;

    // datapath status seen by the sequencer
    typedef struct packed {
        logic lt2;
        logic lt4;
        logic rem0;
        logic dgtq;
    } t_flags;

    // sequencer commands to the datapath
    typedef struct packed {
        logic  load;
        t_d_op d_op;
        logic  div_start;
    } t_dp_ctrl;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_WAIT,
        S_HOLD
    } t_state;

    // control program
    function automatic t_uword ucode(input t_pc pc);
        t_uword w;
        case (pc)
            t_pc'(0):  w = '{D_HOLD, 1'b0, C_LT2,    1'b1, 1'b0, PC_START};
            t_pc'(1):  w = '{D_HOLD, 1'b0, C_LT4,    1'b1, 1'b1, PC_START};
            t_pc'(2):  w = '{D_SET2, 1'b1, C_NEVER,  1'b0, 1'b0, PC_START};
            t_pc'(3):  w = '{D_HOLD, 1'b0, C_REM0,   1'b1, 1'b0, PC_START};
            t_pc'(4):  w = '{D_SET3, 1'b1, C_NEVER,  1'b0, 1'b0, PC_START};
            t_pc'(5):  w = '{D_HOLD, 1'b0, C_REM0,   1'b1, 1'b0, PC_START};
            t_pc'(6):  w = '{D_SET5, 1'b1, C_NEVER,  1'b0, 1'b0, PC_START};
            t_pc'(7):  w = '{D_HOLD, 1'b0, C_DGTQ,   1'b1, 1'b1, PC_START};
            t_pc'(8):  w = '{D_HOLD, 1'b0, C_REM0,   1'b1, 1'b0, PC_START};
            t_pc'(9):  w = '{D_ADD2, 1'b1, C_NEVER,  1'b0, 1'b0, PC_START};
            t_pc'(10): w = '{D_HOLD, 1'b0, C_REM0,   1'b1, 1'b0, PC_START};
            t_pc'(11): w = '{D_ADD4, 1'b1, C_ALWAYS, 1'b0, 1'b0, PC_LOOP};
            default:   w = '{D_HOLD, 1'b0, C_ALWAYS, 1'b1, 1'b0, PC_START};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

[rtl/tdpt_divider.sv]
// restoring divider, one quotient bit per cycle, gives quotient and remainder
// depends on nothing outside itself
`default_nettype none

module tdpt_divider #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_start,
    input  wire logic [VALUE_WIDTH-1:0] i_dividend,
    input  wire logic [VALUE_WIDTH-1:0] i_divisor,
    output logic                        o_done,
    output logic [VALUE_WIDTH-1:0]      o_quot,
    output logic [VALUE_WIDTH-1:0]      o_rem
);

    localparam int CW = $clog2(VALUE_WIDTH + 1);

    logic                   r_busy, n_busy;
    logic                   r_done, n_done;
    logic [CW-1:0]          r_cnt, n_cnt;
    logic [VALUE_WIDTH-1:0] r_quot, n_quot;
    logic [VALUE_WIDTH-1:0] r_rem, n_rem;
    logic [VALUE_WIDTH-1:0] r_dvs, n_dvs;
    logic [VALUE_WIDTH:0]   shifted;
    logic [VALUE_WIDTH:0]   diff;

    always_comb begin
        shifted = {r_rem, r_quot[VALUE_WIDTH-1]};
        diff    = shifted - {1'b0, r_dvs};
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_quot  = r_quot;
        n_rem   = r_rem;
        n_dvs   = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(VALUE_WIDTH);
            n_quot = i_dividend;
            n_rem  = '0;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            if (!diff[VALUE_WIDTH]) begin
                n_rem = diff[VALUE_WIDTH-1:0];
            end else begin
                n_rem = shifted[VALUE_WIDTH-1:0];
            end
            n_quot = {r_quot[VALUE_WIDTH-2:0], ~diff[VALUE_WIDTH]};
            n_cnt  = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quot <= n_quot;
        r_rem  <= n_rem;
        r_dvs  <= n_dvs;
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

[rtl/tdpt_datapath.sv]
// candidate and divisor registers, shared divider and status flags
// depends on tdpt_pkg and tdpt_divider
`default_nettype none

module tdpt_datapath #(
    parameter int VALUE_WIDTH = tdpt_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire tdpt_pkg::t_dp_ctrl     i_ctrl,
    input  wire logic [VALUE_WIDTH-1:0] i_candidate,
    output tdpt_pkg::t_flags            o_flags,
    output logic                        o_div_done
);

    import tdpt_pkg::*;

    logic [VALUE_WIDTH-1:0] r_n;
    logic [VALUE_WIDTH-1:0] r_d, n_d;
    logic [VALUE_WIDTH-1:0] quot;
    logic [VALUE_WIDTH-1:0] rem;

    always_comb begin
        case (i_ctrl.d_op)
            D_SET2:  n_d = VALUE_WIDTH'(2);
            D_SET3:  n_d = VALUE_WIDTH'(3);
            D_SET5:  n_d = VALUE_WIDTH'(5);
            D_ADD2:  n_d = r_d + VALUE_WIDTH'(2);
            D_ADD4:  n_d = r_d + VALUE_WIDTH'(4);
            default: n_d = r_d;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_n <= i_candidate;
        end
        r_d <= n_d;
    end

    tdpt_divider #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_ctrl.div_start),
        .i_dividend (r_n),
        .i_divisor  (n_d),
        .o_done     (o_div_done),
        .o_quot     (quot),
        .o_rem      (rem)
    );

    assign o_flags.lt2  = (r_n < VALUE_WIDTH'(2));
    assign o_flags.lt4  = (r_n < VALUE_WIDTH'(4));
    assign o_flags.rem0 = (rem == '0);
    assign o_flags.dgtq = (r_d > quot);

endmodule

`default_nettype wire

[rtl/tdpt_seq.sv]
// microcoded sequencer: step counter, control table, handshakes and result register
// depends on tdpt_pkg
`default_nettype none

module tdpt_seq (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic                    o_out_is_prime,
    input  wire tdpt_pkg::t_flags   i_flags,
    input  wire logic               i_div_done,
    output tdpt_pkg::t_dp_ctrl      o_ctrl
);

    import tdpt_pkg::*;

    t_state r_state, n_state;
    t_pc    r_pc, n_pc;
    logic   r_res, n_res;
    logic   r_out_valid, n_out_valid;
    logic   r_out_prime, n_out_prime;
    t_uword uw;
    logic   cond_true;
    logic   do_fin;
    logic   fin_val;

    always_comb begin
        case (uw.cond)
            C_ALWAYS: cond_true = 1'b1;
            C_LT2:    cond_true = i_flags.lt2;
            C_LT4:    cond_true = i_flags.lt4;
            C_REM0:   cond_true = i_flags.rem0;
            C_DGTQ:   cond_true = i_flags.dgtq;
            default:  cond_true = 1'b0;
        endcase
    end

    always_comb begin
        uw          = ucode(r_pc);
        n_state     = r_state;
        n_pc        = r_pc;
        n_res       = r_res;
        n_out_valid = r_out_valid & i_out_stall;
        n_out_prime = r_out_prime;
        o_ctrl      = '{1'b0, D_HOLD, 1'b0};
        do_fin      = 1'b0;
        fin_val     = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctrl.load = 1'b1;
                    n_pc        = PC_START;
                    n_state     = S_RUN;
                end
            end
            S_RUN: begin
                o_ctrl.d_op = uw.d_op;
                if (uw.div) begin
                    o_ctrl.div_start = 1'b1;
                    n_state          = S_WAIT;
                end else if (cond_true && uw.fin) begin
                    do_fin  = 1'b1;
                    fin_val = uw.res;
                end else if (cond_true) begin
                    n_pc = uw.target;
                end else begin
                    n_pc = r_pc + t_pc'(1);
                end
            end
            S_WAIT: begin
                if (i_div_done) begin
                    n_state = S_RUN;
                    n_pc    = cond_true ? uw.target : r_pc + t_pc'(1);
                end
            end
            S_HOLD: begin
                do_fin  = 1'b1;
                fin_val = r_res;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (do_fin) begin
            if (!n_out_valid) begin
                n_out_valid = 1'b1;
                n_out_prime = fin_val;
                n_state     = S_IDLE;
            end else begin
                n_res   = fin_val;
                n_state = S_HOLD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pc        <= PC_START;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pc        <= n_pc;
            r_out_valid <= n_out_valid;
        end
        r_res       <= n_res;
        r_out_prime <= n_out_prime;
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_out_is_prime = r_out_prime;

endmodule

`default_nettype wire

[rtl/trial_division_prime_test.sv]
// operation: the item is taken, n < 2 is rejected, 2 and 3 are accepted and multiples
//   of 2 and 3 are ruled out, then each tested divisor pair takes two divides plus
//   three test steps, until the divisor exceeds the quotient
// throughput: one item at a time; the shared one-bit-per-cycle divider sets the rate
// the result sits in an output register, so a new item is taken while it waits
// reset: synchronous active low, clears the sequencer and the output valid
`default_nettype none

// top level: sequencer drives the divider datapath from its control table
module trial_division_prime_test #(
    parameter int VALUE_WIDTH = tdpt_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // input item channel
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire logic [VALUE_WIDTH-1:0] i_in_candidate,
    // result item channel
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output logic                        o_out_is_prime
);

    import tdpt_pkg::*;

    // status flags back from the datapath: n below 2, n below 4,
    // last remainder zero, divisor above the last quotient (i*i > n)
    t_flags   flags;
    // per-cycle commands: load candidate, divisor update, divider start
    t_dp_ctrl ctrl;
    logic     div_done;

    // program: reject n < 2, accept 2 and 3, reject multiples of 2 and 3,
    // then loop over d = 5, 11, 17 ... testing d and d+2 until d > n/d
    tdpt_seq u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_is_prime (o_out_is_prime),
        .i_flags        (flags),
        .i_div_done     (div_done),
        .o_ctrl         (ctrl)
    );

    // the quotient of n/d doubles as the square bound, so no multiplier is needed
    tdpt_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .i_candidate (i_in_candidate),
        .o_flags     (flags),
        .o_div_done  (div_done)
    );

endmodule

`default_nettype wire

[rtl/tdpt_checker.sv]
// port-level checks for the trial division prime test, bound to the top level
// depends on trial_division_prime_test ports
`default_nettype none

module tdpt_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic o_in_stall,
    input wire logic o_out_valid,
    input wire logic i_out_stall,
    input wire logic o_out_is_prime
);

    // a result waiting on stall stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result dropped while stalled");

    // and keeps its value
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(o_out_is_prime))
        else $error("result changed while stalled");

    // an accepted item keeps the block busy for at least the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after accept");

    // no result is offered right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a result can't appear the cycle after an item is taken from idle
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && !o_out_valid) |=> !o_out_valid)
        else $error("result without processing");

endmodule

bind trial_division_prime_test tdpt_checker u_tdpt_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_out_is_prime (o_out_is_prime)
);

`default_nettype wire
